// ===== design/tcpjq_pkg.sv =====
`timescale 1ns / 1ps

package tcpjq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_CLASSES = 3;
   localparam int JOB_W       = 7;
   localparam int BOUND_W     = 7;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CLASS_IDX_W = $clog2(NUM_CLASSES);

   typedef logic [JOB_W-1:0]   job_type;
   typedef logic [BOUND_W-1:0] bound_type;
   typedef logic [1:0]         class_type;
   typedef logic [2:0]         kind_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   // Request operations
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Job classes, highest priority first
   localparam class_type CLASS_SERVER = 2'd0;
   localparam class_type CLASS_POWER  = 2'd1;
   localparam class_type CLASS_USER   = 2'd2;
   localparam class_type CLASS_NONE   = 2'd3;

   // Configuration register indexes
   localparam csr_index_type REG_SERVER_UPPER = 2'd0;
   localparam csr_index_type REG_POWER_UPPER  = 2'd1;
   localparam csr_index_type REG_USER_UPPER   = 2'd2;

   // Bound values after reset
   localparam bound_type SERVER_UPPER_RESET = 7'd30;
   localparam bound_type POWER_UPPER_RESET  = 7'd60;
   localparam bound_type USER_UPPER_RESET   = 7'd100;

   // Bundle of the three class bounds
   typedef struct packed {
      bound_type server_upper;
      bound_type power_upper;
      bound_type user_upper;
   } bounds_type;

   // Job number modulo 5: 16 is 1 mod 5, so fold nibbles, then trim
   function automatic kind_type kind_of(job_type n);
      logic [4:0] s;
      s = 5'(n[6:4]) + 5'(n[3:0]);
      if (s >= 5'd20) s = s - 5'd20;
      if (s >= 5'd10) s = s - 5'd10;
      if (s >= 5'd5)  s = s - 5'd5;
      return kind_type'(s[2:0]);
   endfunction

   // Flat store address of a queue slot
   function automatic addr_type store_addr(class_type c, ptr_type p);
      return addr_type'(addr_type'(c) * addr_type'(QUEUE_DEPTH)) + addr_type'(p);
   endfunction

endpackage

// ===== design/tcpjq_req_if.sv =====
`timescale 1ns / 1ps

interface tcpjq_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   tcpjq_pkg::job_type job_number;

   modport source (output valid, output op, output job_number, input ready);
   modport sink   (input valid, input op, input job_number, output ready);
endinterface

// ===== design/tcpjq_rsp_if.sv =====
`timescale 1ns / 1ps

interface tcpjq_rsp_if;
   logic                  valid;
   logic                  ready;
   tcpjq_pkg::status_type status;
   tcpjq_pkg::job_type    job_out;
   tcpjq_pkg::class_type  job_class;
   tcpjq_pkg::kind_type   job_kind;

   modport source (output valid, output status, output job_out, output job_class,
                   output job_kind, input ready);
   modport sink   (input valid, input status, input job_out, input job_class,
                   input job_kind, output ready);
endinterface

// ===== design/tcpjq_csr_if.sv =====
`timescale 1ns / 1ps

interface tcpjq_csr_if;
   logic                     valid;
   logic                     ready;
   tcpjq_pkg::csr_index_type index;
   logic [6:0]               data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/tcpjq_classify.sv =====
`timescale 1ns / 1ps

module tcpjq_classify (
   input  tcpjq_pkg::job_type    job_number,
   input  tcpjq_pkg::bounds_type bounds,
   output tcpjq_pkg::class_type  job_class
);
   import tcpjq_pkg::*;

   logic [BOUND_W:0] n_ext;
   logic [BOUND_W:0] server_lo;
   logic [BOUND_W:0] power_lo;

   assign n_ext     = (BOUND_W + 1)'(job_number);
   assign server_lo = (BOUND_W + 1)'(bounds.server_upper) + 1'b1;
   assign power_lo  = (BOUND_W + 1)'(bounds.power_upper) + 1'b1;

   // Try the ranges in priority order; out-of-order bounds leave gaps
   always_comb begin
      priority if (n_ext >= 1 && n_ext <= (BOUND_W + 1)'(bounds.server_upper)) begin
         job_class = CLASS_SERVER;
      end else if (n_ext >= server_lo && n_ext <= (BOUND_W + 1)'(bounds.power_upper)) begin
         job_class = CLASS_POWER;
      end else if (n_ext >= power_lo && n_ext <= (BOUND_W + 1)'(bounds.user_upper)) begin
         job_class = CLASS_USER;
      end else begin
         job_class = CLASS_NONE;
      end
   end

endmodule

// ===== design/three_class_priority_job_queue_unit.sv =====
`timescale 1ns / 1ps

// Three-class strict-priority job queue. An enqueue request classes its job
// number against the server, power user and user upper bounds and appends it
// to that class's FIFO (64 entries each); a number in no range, or one whose
// queue is full, is dropped and reported. A dequeue request pops the head of
// the highest-priority non-empty queue and returns it with its class and its
// kind (number mod 5), or job 0 with an empty status when all queues are
// empty. Every request gives exactly one response. The store is accessed in
// the cycle the request is taken and has a registered read; the response is
// formed in the result state when the output register is free. No new request
// is taken before that response is written into it. A response
// waiting in the output register does not block the next request. Bound
// registers are written through the csr channel, which is always ready;
// write them only while no request is outstanding. No clearing pass is needed
// after reset.
module three_class_priority_job_queue_unit (
   input logic        clock,
   input logic        reset,
   tcpjq_req_if.sink   req_chan,
   tcpjq_rsp_if.source rsp_chan,
   tcpjq_csr_if.sink   csr_chan
);
   import tcpjq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_RESULT
   } state_type;

   // Configuration
   bounds_type bounds_ff, bounds_in;

   // Queue control
   ptr_type rd_ptr_ff [NUM_CLASSES];
   ptr_type rd_ptr_in [NUM_CLASSES];
   ptr_type wr_ptr_ff [NUM_CLASSES];
   ptr_type wr_ptr_in [NUM_CLASSES];
   cnt_type count_ff  [NUM_CLASSES];
   cnt_type count_in  [NUM_CLASSES];

   // Store
   job_type  store_mem [STORE_DEPTH];
   job_type  rdata_ff;
   logic     mem_we;
   logic     mem_re;
   addr_type mem_addr;

   // Pending result
   state_type  state_ff, state_in;
   status_type pend_status_ff, pend_status_in;
   class_type  pend_class_ff, pend_class_in;
   job_type    pend_job_ff, pend_job_in;
   logic       pend_mem_ff, pend_mem_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   job_type    rsp_job_ff, rsp_job_in;
   class_type  rsp_class_ff, rsp_class_in;
   kind_type   rsp_kind_ff, rsp_kind_in;

   class_type  enq_class;
   logic       req_accept;
   logic       out_free;
   job_type    res_job;

   tcpjq_classify u_classify (
      .job_number (req_chan.job_number),
      .bounds     (bounds_ff),
      .job_class  (enq_class)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.job_out   = rsp_job_ff;
   assign rsp_chan.job_class = rsp_class_ff;
   assign rsp_chan.job_kind  = rsp_kind_ff;

   // Bound register writes; unknown indexes are dropped
   always_comb begin
      bounds_in = bounds_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            REG_SERVER_UPPER: bounds_in.server_upper = bound_type'(csr_chan.data);
            REG_POWER_UPPER:  bounds_in.power_upper  = bound_type'(csr_chan.data);
            REG_USER_UPPER:   bounds_in.user_upper   = bound_type'(csr_chan.data);
            default:          bounds_in = bounds_ff;
         endcase
      end
   end

   // Service the request: update pointers and counts, access the store
   always_comb begin
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      count_in       = count_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = '0;
      pend_status_in = pend_status_ff;
      pend_class_in  = pend_class_ff;
      pend_job_in    = pend_job_ff;
      pend_mem_in    = pend_mem_ff;
      if (req_accept) begin
         pend_mem_in = 1'b0;
         if (req_chan.op == OP_ENQUEUE) begin
            pend_job_in   = req_chan.job_number;
            pend_class_in = enq_class;
            if (enq_class == CLASS_NONE) begin
               pend_status_in = STATUS_RANGE;
            end else if (count_ff[enq_class[CLASS_IDX_W-1:0]] == cnt_type'(QUEUE_DEPTH)) begin
               pend_status_in = STATUS_FULL;
            end else begin
               pend_status_in = STATUS_OK;
               mem_we         = 1'b1;
               mem_addr       = store_addr(enq_class, wr_ptr_ff[enq_class[CLASS_IDX_W-1:0]]);
               wr_ptr_in[enq_class[CLASS_IDX_W-1:0]] =
                  (wr_ptr_ff[enq_class[CLASS_IDX_W-1:0]] == ptr_type'(QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr_ff[enq_class[CLASS_IDX_W-1:0]] + 1'b1;
               count_in[enq_class[CLASS_IDX_W-1:0]] =
                  count_ff[enq_class[CLASS_IDX_W-1:0]] + 1'b1;
            end
         end else begin
            pend_status_in = STATUS_EMPTY;
            pend_class_in  = CLASS_NONE;
            pend_job_in    = '0;
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
               if (count_ff[c] != '0) begin
                  pend_class_in = class_type'(c);
               end
            end
            if (pend_class_in != CLASS_NONE) begin
               pend_status_in = STATUS_OK;
               pend_mem_in    = 1'b1;
               mem_re         = 1'b1;
               mem_addr       = store_addr(pend_class_in,
                                           rd_ptr_ff[pend_class_in[CLASS_IDX_W-1:0]]);
               rd_ptr_in[pend_class_in[CLASS_IDX_W-1:0]] =
                  (rd_ptr_ff[pend_class_in[CLASS_IDX_W-1:0]] == ptr_type'(QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr_ff[pend_class_in[CLASS_IDX_W-1:0]] + 1'b1;
               count_in[pend_class_in[CLASS_IDX_W-1:0]] =
                  count_ff[pend_class_in[CLASS_IDX_W-1:0]] - 1'b1;
            end
         end
      end
   end

   // Form the response and advance the output register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign res_job  = pend_mem_ff ? rdata_ff : pend_job_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_kind_in   = rsp_kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_job_in    = res_job;
               rsp_class_in  = pend_class_ff;
               rsp_kind_in   = kind_of(res_job);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   // Pending result payload
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_class_ff  <= pend_class_in;
      pend_job_ff    <= pend_job_in;
      pend_mem_ff    <= pend_mem_in;
   end

   // Bounds, pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.server_upper <= SERVER_UPPER_RESET;
         bounds_ff.power_upper  <= POWER_UPPER_RESET;
         bounds_ff.user_upper   <= USER_UPPER_RESET;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_ptr_ff[c] <= '0;
            wr_ptr_ff[c] <= '0;
            count_ff[c]  <= '0;
         end
      end else begin
         bounds_ff <= bounds_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job store: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= pend_job_in;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

endmodule
